// ===== design/tzsp_pkg.sv =====
// Shared types, constants and helpers for the TZSP decapsulator.
`timescale 1ns / 1ps
`default_nettype none

package tzsp_pkg;

	// Tagged fields walked at most before the rest is taken as payload
	localparam int MAX_FIELDS = 32;

	localparam int BYTE_W   = 8;
	localparam int FCNT_W   = 8;   // saturating field counter, as wide as a tag count may go
	localparam int COUNT_W  = 6;   // reported field count
	localparam int QDEPTH   = 2;   // entries between front and back, power of two
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int TDATA_W  = 16;  // out byte, status, field count

	localparam logic [BYTE_W-1:0] TAG_END     = 8'h01;
	localparam logic [BYTE_W-1:0] TAG_MAX_1B  = 8'h02;  // tags up to this one have no length byte
	localparam int                NOFIELDS_BIT = 0;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TAG,
		PH_LEN,
		PH_SKIP,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	// One result as it travels from the parser to the output stage
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		status_t            status;
		logic               eop;
		logic               has_byte;
		logic [BYTE_W-1:0]  data;
	} rec_t;

	// Phase after a field is complete
	function automatic phase_t after_field(input logic [FCNT_W-1:0] n);
		return (n >= FCNT_W'(MAX_FIELDS)) ? PH_PAYLOAD : PH_TAG;
	endfunction

endpackage

`default_nettype wire

// ===== design/tzsp_front.sv =====
// Byte parser: header, tagged field walk, classification into results.
`timescale 1ns / 1ps
`default_nettype none

module tzsp_front import tzsp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	output rec_t                   rec,
	output logic                   push
);

	phase_t              phase_q, phase_d, phase_upd;
	logic [1:0]          hdr_idx_q, hdr_idx_d;
	logic                nof_q, nof_d;
	logic [FCNT_W-1:0]   fields_q, fields_d, fields_upd;
	logic [BYTE_W-1:0]   skip_q, skip_d;

	// next state
	always_comb begin
		phase_upd  = phase_q;
		hdr_idx_d  = hdr_idx_q;
		nof_d      = nof_q;
		fields_upd = fields_q;
		skip_d     = skip_q;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_idx_q == 2'd1)
					nof_d = in_byte[NOFIELDS_BIT];
				hdr_idx_d = hdr_idx_q + 2'd1;
				if (hdr_idx_q == 2'd3)
					phase_upd = nof_d ? PH_PAYLOAD : PH_TAG;
			end
			PH_TAG: begin
				if (fields_q != {FCNT_W{1'b1}})
					fields_upd = fields_q + FCNT_W'(1);
				if (in_byte > TAG_MAX_1B)
					phase_upd = PH_LEN;
				else if (in_byte == TAG_END)
					phase_upd = PH_PAYLOAD;
				else
					phase_upd = after_field(fields_upd);
			end
			PH_LEN: begin
				skip_d    = in_byte;
				phase_upd = (in_byte == '0) ? after_field(fields_q) : PH_SKIP;
			end
			PH_SKIP: begin
				skip_d = skip_q - BYTE_W'(1);
				if (skip_q == BYTE_W'(1))
					phase_upd = after_field(fields_q);
			end
			PH_PAYLOAD: begin
			end
			default: begin
				phase_upd = PH_HEADER;
			end
		endcase

		phase_d  = phase_upd;
		fields_d = fields_upd;
		if (in_last) begin
			// every packet starts from a clean slate
			phase_d   = PH_HEADER;
			hdr_idx_d = '0;
			nof_d     = 1'b0;
			fields_d  = '0;
			skip_d    = '0;
		end
	end

	// outputs
	always_comb begin
		push         = acc && ((phase_q == PH_PAYLOAD) || in_last);
		rec.has_byte = (phase_q == PH_PAYLOAD);
		rec.data     = (phase_q == PH_PAYLOAD) ? in_byte : '0;
		rec.eop      = in_last;
		rec.status   = ST_OK;
		rec.count    = '0;
		if (in_last) begin
			if (phase_upd == PH_HEADER)
				rec.status = ST_SHORT;
			else if (phase_upd != PH_PAYLOAD)
				rec.status = ST_TRUNC;
			rec.count = (fields_upd > FCNT_W'({COUNT_W{1'b1}})) ?
				{COUNT_W{1'b1}} : fields_upd[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_idx_q <= '0;
			nof_q     <= 1'b0;
			fields_q  <= '0;
			skip_q    <= '0;
		end else if (acc) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			nof_q     <= nof_d;
			fields_q  <= fields_d;
			skip_q    <= skip_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/tzsp_queue.sv =====
// Short result queue between parser and output stage.
`timescale 1ns / 1ps
`default_nettype none

module tzsp_queue import tzsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t wr_rec,
	input  wire logic pop,
	output rec_t      rd_rec,
	output logic      not_empty,
	output logic      not_full
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign not_full  = (cnt_q != QCNT_W'(QDEPTH));
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== design/tzsp_back.sv =====
// Output stage: registered result, handed out on the master stream.
`timescale 1ns / 1ps
`default_nettype none

module tzsp_back import tzsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rec_t               rd_rec,
	input  wire logic               not_empty,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);

	rec_t rec_q;
	logic valid_q;

	// refill whenever the register is empty or being emptied
	assign pop = not_empty && (!valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= rd_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {rec_q.count, rec_q.status, rec_q.data};
	assign m_tlast  = rec_q.eop;
	assign m_tuser  = rec_q.has_byte;

endmodule

`default_nettype wire

// ===== design/tzsp_decapsulator.sv =====
// TZSP decapsulator top level: parser front, result queue, output stage.
// A byte that gives a result is written into the queue, then into the output register, and shows on m_tvalid.
// Throughput: one byte per cycle while s_tready is high; header and field bytes give no result on their own.
// s_tready drops only when both queue entries are full behind a stalled output register.
// Reset (arst_n low) puts the parser in header phase, empties the queue and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module tzsp_decapsulator import tzsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input stream: one packet byte per request
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
	input  wire logic               s_tlast,   // in_last
	// result stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] field_count
	output logic                    m_tlast,   // end_of_packet
	output logic                    m_tuser    // [0] has_byte
);

	rec_t front_rec, rd_rec;
	logic acc, push, pop, not_empty, not_full;

	// The parser never stalls on its own; the queue's free space is the only
	// thing that can hold off a request.
	assign s_tready = not_full;
	assign acc      = s_tvalid && s_tready;

	// Front: header skip, no-fields flag, tagged field walk, result build.
	tzsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.rec     (front_rec),
		.push    (push)
	);

	// Queue decouples parsing from the downstream handshake.
	tzsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (front_rec),
		.pop       (pop),
		.rd_rec    (rd_rec),
		.not_empty (not_empty),
		.not_full  (not_full)
	);

	// Back: output register feeding the master side.
	tzsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_rec    (rd_rec),
		.not_empty (not_empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the TZSP decapsulator: directed and random packets, checked per result.
`timescale 1ns / 1ps

module tb import tzsp_pkg::*;;

	// Run stops here whatever happens, with a failure reported
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_BYTES  = 950;   // per random phase, two phases
	localparam int SETTLE_CYCLES = 8;     // slack after the last expected result
	localparam int REPORT_MAX    = 10;

	localparam logic [BYTE_W-1:0]  TAG_PAD   = 8'h00;
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	// One result as the block presents it, compared as a whole
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               has_byte;
		logic               eop;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} decap_res_t;

	logic clk = 1'b0;
	logic arst_n;

	logic               s_tvalid;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;   // [7:0] out_byte, [9:8] status, [15:10] field_count
	logic               m_tlast;   // end_of_packet
	logic               m_tuser;   // [0] has_byte

	tzsp_decapsulator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Parser state as the predictor sees it
	phase_t            ph;
	logic [1:0]        hdr_idx;
	logic              nofld;
	logic [7:0]        fld_cnt;   // saturates at 255, reported clipped to 63
	logic [BYTE_W-1:0] skip_left;

	decap_res_t        pending_results[$];
	logic [BYTE_W-1:0] pkt_q[$];   // packet being assembled for sending

	int  fail_count = 0;
	int  cycles = 0;
	int  bytes_sent = 0;
	int  rx_hold = 0;     // cycles the result side still holds tready low
	bit  tx_calm = 1'b0;  // no gaps from the sender while set
	bit  rx_calm = 1'b0;  // no stalls from the receiver while set

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic phase_t field_done_phase();
		return (fld_cnt >= MAX_FIELDS) ? PH_PAYLOAD : PH_TAG;
	endfunction

	function automatic void clear_packet_state();
		ph        = PH_HEADER;
		hdr_idx   = '0;
		nofld     = 1'b0;
		fld_cnt   = '0;
		skip_left = '0;
	endfunction

	// Advances the parser by one byte; returns 1 when the byte yields a result
	function automatic bit decap_byte(input logic [BYTE_W-1:0] b, input logic last,
	                                  output decap_res_t r);
		bit pay;
		pay = 1'b0;
		case (ph)
			PH_HEADER: begin
				if (hdr_idx == 2'd1)
					nofld = b[NOFIELDS_BIT];
				hdr_idx = hdr_idx + 2'd1;
				if (hdr_idx == 2'd0)
					ph = nofld ? PH_PAYLOAD : PH_TAG;
			end
			PH_TAG: begin
				if (fld_cnt != 8'hFF)
					fld_cnt = fld_cnt + 8'd1;
				if (b > TAG_MAX_1B)
					ph = PH_LEN;
				else if (b == TAG_END)
					ph = PH_PAYLOAD;
				else
					ph = field_done_phase();
			end
			PH_LEN: begin
				skip_left = b;
				ph = (b == '0) ? field_done_phase() : PH_SKIP;
			end
			PH_SKIP: begin
				skip_left = skip_left - 1'b1;
				if (skip_left == '0)
					ph = field_done_phase();
			end
			PH_PAYLOAD: pay = 1'b1;
			default: ph = PH_HEADER;
		endcase

		r = '0;
		if (!pay && !last)
			return 1'b0;

		r.data     = pay ? b : '0;
		r.has_byte = pay;
		r.eop      = last;
		r.status   = ST_OK;
		if (last) begin
			if (ph == PH_HEADER)
				r.status = ST_SHORT;
			else if (ph != PH_PAYLOAD)
				r.status = ST_TRUNC;
			r.count = (fld_cnt > COUNT_SAT) ? COUNT_SAT : fld_cnt[COUNT_W-1:0];
			clear_packet_state();
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Sender: drives at the falling edge, request taken at the rising edge
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		decap_res_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		// valid is lowered only when a gap follows, so it never drops and rises in one step
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (decap_byte(b, last, r))
			pending_results.push_back(r);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drop_valid();
		s_tvalid <= 1'b0;
	endtask

	task automatic send_packet();
		foreach (pkt_q[i])
			send_byte(pkt_q[i], i == pkt_q.size() - 1);
		pkt_q.delete();
	endtask

	// ------------------------------------------------------------------
	// Packet building
	// ------------------------------------------------------------------
	task automatic add_random_bytes(input int n);
		repeat (n) pkt_q.push_back(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic add_header(input bit no_fields);
		logic [BYTE_W-1:0] flags;
		flags = BYTE_W'($urandom_range(0, 255));
		flags[NOFIELDS_BIT] = no_fields;
		add_random_bytes(1);
		pkt_q.push_back(flags);
		add_random_bytes(2);
	endtask

	// Pad, one-byte tag, or a long tag with length and skipped data
	task automatic add_field();
		int k;
		int len;
		k = $urandom_range(0, 9);
		if (k < 3)
			pkt_q.push_back(TAG_PAD);
		else if (k < 5)
			pkt_q.push_back(TAG_MAX_1B);
		else begin
			pkt_q.push_back(BYTE_W'($urandom_range(TAG_MAX_1B + 1, 255)));
			k = $urandom_range(0, 99);
			len = (k == 0) ? 255 : (k < 8) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			pkt_q.push_back(BYTE_W'(len));
			add_random_bytes(len);
		end
	endtask

	task automatic build_packet();
		bit no_fields;
		int nf;
		no_fields = ($urandom_range(0, 99) < 15);
		add_header(no_fields);
		if (!no_fields) begin
			// now and then enough fields to run into the field limit
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_FIELDS - 4, MAX_FIELDS + 4)
			                                 : $urandom_range(0, 5);
			repeat (nf) add_field();
			if (nf < MAX_FIELDS && $urandom_range(0, 9) != 0)
				pkt_q.push_back(TAG_END);
		end
		add_random_bytes($urandom_range(0, 16));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_header_cases();
		pkt_q = '{8'hFF};                       // one-byte packet: short header
		send_packet();
		pkt_q = '{8'h00, 8'hFE, 8'h00};         // three bytes, still short
		send_packet();
		pkt_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};  // no-fields set, header only: ok, no payload
		send_packet();
		pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00};  // flag clear, tag missing
		send_packet();
	endtask

	task automatic test_field_walk();
		// pad, one-byte tag, long tag with one data byte, zero length, end, payload extremes
		add_header(1'b0);
		pkt_q.push_back(TAG_PAD);
		pkt_q.push_back(TAG_MAX_1B);
		pkt_q.push_back(8'hFF);
		pkt_q.push_back(8'h01);
		pkt_q.push_back(8'hAA);
		pkt_q.push_back(8'h03);
		pkt_q.push_back(8'h00);
		pkt_q.push_back(TAG_END);
		pkt_q.push_back(8'h00);
		pkt_q.push_back(8'hFF);
		send_packet();
		// end tag as the last byte: empty payload
		add_header(1'b0);
		pkt_q.push_back(TAG_END);
		send_packet();
	endtask

	task automatic test_truncated_packets();
		add_header(1'b0);                       // ends on a long tag
		pkt_q.push_back(8'h80);
		send_packet();
		add_header(1'b0);                       // ends on the length byte
		pkt_q.push_back(8'h80);
		pkt_q.push_back(8'h03);
		send_packet();
		add_header(1'b0);                       // ends inside the skipped data
		pkt_q.push_back(8'h80);
		pkt_q.push_back(8'h03);
		pkt_q.push_back(8'h11);
		send_packet();
		add_header(1'b0);                       // pad then nothing: tag missing
		pkt_q.push_back(TAG_PAD);
		send_packet();
	endtask

	task automatic test_field_limit();
		// full field list with no end tag; the byte after it looks like an end tag
		add_header(1'b0);
		for (int i = 0; i < MAX_FIELDS; i++)
			pkt_q.push_back(i[0] ? TAG_MAX_1B : TAG_PAD);
		pkt_q.push_back(TAG_END);
		pkt_q.push_back(8'h5A);
		send_packet();
	endtask

	task automatic test_random_traffic(input int n_bytes);
		int goal;
		int k;
		int keep;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			// flip the idling modes now and then to get stretches without gaps
			if ($urandom_range(0, 9) == 0)
				tx_calm = !tx_calm;
			if ($urandom_range(0, 9) == 0)
				rx_calm = !rx_calm;
			k = $urandom_range(0, 99);
			if (k < 85) begin
				build_packet();
				if (k >= 70) begin
					keep = $urandom_range(1, pkt_q.size());
					while (pkt_q.size() > keep)
						void'(pkt_q.pop_back());
				end
			end else
				add_random_bytes($urandom_range(1, 12));
			send_packet();
		end
	endtask

	// Sender holds off until the result side has caught up completely
	task automatic test_drain_pause();
		drop_valid();
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: stalls drawn per result, change at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		decap_res_t got;
		decap_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.data     = m_tdata[7:0];
			got.status   = status_t'(m_tdata[9:8]);
			got.count    = m_tdata[15:10];
			got.eop      = m_tlast;
			got.has_byte = m_tuser;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: unexpected: data %h has %b eop %b st %0d cnt %0d",
					         $time, got.data, got.has_byte, got.eop, got.status,
					         got.count);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("%0t: mismatch exp data %h has %b eop %b st %0d cnt %0d",
						         $time, want.data, want.has_byte, want.eop,
						         want.status, want.count);
						$display("%0t:          got data %h has %b eop %b st %0d cnt %0d",
						         $time, got.data, got.has_byte, got.eop,
						         got.status, got.count);
					end
				end
			end
			rx_hold = rx_calm ? 0 : $urandom_range(0, 15);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		clear_packet_state();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_header_cases();
		test_field_walk();
		test_truncated_packets();
		test_field_limit();
		test_random_traffic(RANDOM_BYTES);
		test_drain_pause();
		test_random_traffic(RANDOM_BYTES);

		drop_valid();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== tzsp_decapsulator.f =====
design/tzsp_pkg.sv
design/tzsp_front.sv
design/tzsp_queue.sv
design/tzsp_back.sv
design/tzsp_decapsulator.sv
tb/tb.sv
